// ===== rtl/cwr_pkg.sv =====
`default_nettype none

package cwr_pkg;

   // Duration and reminder limits.
   localparam logic [31:0] MIN_DURATION_MS = 32'd1000;
   localparam logic [31:0] MAX_DURATION_MS = 32'd86400000;
   localparam logic [9:0]  REMINDER_MIN    = 10'd1;
   localparam logic [9:0]  REMINDER_MAX    = 10'd720;
   localparam logic [15:0] MS_PER_MIN      = 16'd60000;

   // Command codes carried in the mode field.
   localparam logic [2:0] MODE_POLL   = 3'd0;
   localparam logic [2:0] MODE_START  = 3'd1;
   localparam logic [2:0] MODE_PAUSE  = 3'd2;
   localparam logic [2:0] MODE_RESUME = 3'd3;
   localparam logic [2:0] MODE_RESET  = 3'd4;
   localparam logic [2:0] MODE_SET    = 3'd5;
   localparam logic [2:0] MODE_ADJUST = 3'd6;

   // One quotient bit per divider step; the dividend is 33 bits wide.
   localparam int DIV_STEPS = 33;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      PH_READY    = 2'd0,
      PH_RUNNING  = 2'd1,
      PH_PAUSED   = 2'd2,
      PH_FINISHED = 2'd3
   } phase_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_init;
      logic div_step;
      logic mul;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/cwr_ctrl.sv =====
`default_nettype none

module cwr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cwr_pkg::status_type status,
   output cwr_pkg::cmd_type    cmd
);
   import cwr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_INIT,
      S_DIV,
      S_MUL,
      S_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             slot_free;

   // The result register may still hold the previous beat; wait for it to drain.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load     = (state_ff == S_IDLE) && req_valid;
   assign cmd.prep     = (state_ff == S_PREP);
   assign cmd.div_init = (state_ff == S_INIT);
   assign cmd.div_step = (state_ff == S_DIV);
   assign cmd.mul      = (state_ff == S_MUL);
   assign cmd.commit   = (state_ff == S_DONE) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               state_ff <= S_INIT;
            end
            S_INIT: begin
               cnt_ff <= '0;
               if (status.need_div) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DIV: begin
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_MUL: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cwr_datapath.sv =====
`default_nettype none

module cwr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  cwr_pkg::cmd_type    cmd,
   output cwr_pkg::status_type status,
   input  logic [2:0]          req_mode,
   input  logic [47:0]         req_now_ms,
   input  logic signed [32:0]  req_duration_arg,
   input  logic                csr_wr_en,
   input  logic [9:0]          csr_wr_data,
   output logic                rsp_accepted,
   output logic [1:0]          rsp_phase,
   output logic [31:0]         rsp_remaining_ms,
   output logic                rsp_finished_now,
   output logic [16:0]         rsp_milestone_minutes
);
   import cwr_pkg::*;

   // Configuration and timer state.
   logic [9:0]  interval_ff;
   phase_type   phase_ff,  phase_in;
   logic [31:0] dur_ff,    dur_in;
   logic [31:0] held_ff,   held_in;
   logic [48:0] end_ff,    end_in;
   logic [31:0] last_ff,   last_in;

   // Latched command beat.
   logic [2:0]         mode_ff;
   logic [47:0]        now_ff;
   logic signed [32:0] arg_ff;

   // Values prepared from the command.
   logic [31:0] rem_ff,     rem_in;
   logic [25:0] step_ff,    step_in;
   logic        ok_ff,      ok_in;
   logic [31:0] clamp_ff,   clamp_in;
   logic [48:0] end_new_ff, end_new_in;

   // Serial divider and milestone check.
   logic [32:0] n_ff, n_in;
   logic [32:0] num_ff;
   logic [25:0] rmd_ff;
   logic [26:0] trial;
   logic        trial_ge;
   logic [32:0] mstep;
   logic        hit_ff;
   logic [26:0] mile_ff;

   // Result register.
   logic        acc_o_ff,  acc_in;
   logic [1:0]  phase_o_ff;
   logic [31:0] rem_o_ff,  rem_o_in;
   logic        fin_o_ff,  fin_in;
   logic [16:0] mile_o_ff, mile_in;

   logic [49:0]        diff;
   logic [31:0]        run_rem;
   logic signed [33:0] arg_ext;
   logic signed [33:0] edit_val;

   // Remaining time at the command's timestamp, as seen before the command.
   always_comb begin
      diff = {1'b0, end_ff} - {2'b00, now_ff};
      if (end_ff <= {1'b0, now_ff}) begin
         run_rem = '0;
      end else if (diff[49:32] != '0) begin
         run_rem = '1;
      end else begin
         run_rem = diff[31:0];
      end
      rem_in = (phase_ff == PH_RUNNING) ? run_rem : held_ff;
   end

   assign step_in = {16'b0, interval_ff} * {10'b0, MS_PER_MIN};
   assign ok_in   = (interval_ff != '0) && (interval_ff >= REMINDER_MIN)
                    && (interval_ff <= REMINDER_MAX);

   always_comb begin
      arg_ext = {arg_ff[32], arg_ff};
      if (mode_ff == MODE_SET) begin
         edit_val = arg_ext;
      end else begin
         edit_val = $signed({2'b00, dur_ff}) + arg_ext;
      end
      priority if (edit_val < $signed({2'b00, MIN_DURATION_MS})) begin
         clamp_in = MIN_DURATION_MS;
      end else if (edit_val > $signed({2'b00, MAX_DURATION_MS})) begin
         clamp_in = MAX_DURATION_MS;
      end else begin
         clamp_in = edit_val[31:0];
      end
   end

   assign end_new_in = {1'b0, now_ff}
                       + {17'b0, ((mode_ff == MODE_RESUME) ? held_ff : dur_ff)};

   // Ceiling division: divide rem + step - 1 by step, then the multiple of
   // step at or above rem is the dividend minus the remainder.
   assign n_in     = {1'b0, rem_ff} + {7'b0, step_ff} - 33'd1;
   assign trial    = {rmd_ff, num_ff[32]};
   assign trial_ge = (trial >= {1'b0, step_ff});
   assign mstep    = n_ff - {7'b0, rmd_ff};

   assign status.need_div = (mode_ff == MODE_POLL) && (phase_ff == PH_RUNNING)
                            && (rem_ff != '0) && ok_ff;

   always_comb begin
      phase_in = phase_ff;
      dur_in   = dur_ff;
      held_in  = held_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      acc_in   = 1'b1;
      fin_in   = 1'b0;
      mile_in  = '0;
      rem_o_in = rem_ff;
      unique case (mode_ff)
         MODE_POLL: begin
            if (phase_ff == PH_RUNNING) begin
               if (rem_ff == '0) begin
                  phase_in = PH_FINISHED;
                  held_in  = '0;
                  last_in  = '0;
                  fin_in   = 1'b1;
               end else if (ok_ff) begin
                  last_in = rem_ff;
                  if (hit_ff) begin
                     mile_in = (mile_ff[26:17] != '0) ? '1 : mile_ff[16:0];
                  end
               end
            end
         end
         MODE_START: begin
            if (phase_ff == PH_RUNNING || phase_ff == PH_PAUSED) begin
               acc_in = 1'b0;
            end else begin
               end_in   = end_new_ff;
               held_in  = dur_ff;
               last_in  = dur_ff;
               phase_in = PH_RUNNING;
               rem_o_in = dur_ff;
            end
         end
         MODE_PAUSE: begin
            if (phase_ff == PH_RUNNING) begin
               held_in  = rem_ff;
               phase_in = PH_PAUSED;
            end else begin
               acc_in = 1'b0;
            end
         end
         MODE_RESUME: begin
            if (phase_ff == PH_PAUSED) begin
               end_in   = end_new_ff;
               phase_in = PH_RUNNING;
            end else begin
               acc_in = 1'b0;
            end
         end
         MODE_RESET: begin
            phase_in = PH_READY;
            held_in  = dur_ff;
            end_in   = '0;
            last_in  = '0;
            rem_o_in = dur_ff;
         end
         MODE_SET, MODE_ADJUST: begin
            if (phase_ff == PH_RUNNING || phase_ff == PH_PAUSED) begin
               acc_in = 1'b0;
            end else begin
               dur_in   = clamp_ff;
               held_in  = clamp_ff;
               phase_in = PH_READY;
               rem_o_in = clamp_ff;
            end
         end
         default: begin
            acc_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         phase_ff    <= PH_READY;
         dur_ff      <= MIN_DURATION_MS;
         held_ff     <= MIN_DURATION_MS;
         end_ff      <= '0;
         last_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            phase_ff <= phase_in;
            dur_ff   <= dur_in;
            held_ff  <= held_in;
            end_ff   <= end_in;
            last_ff  <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         now_ff  <= req_now_ms;
         arg_ff  <= req_duration_arg;
      end
      if (cmd.prep) begin
         rem_ff     <= rem_in;
         step_ff    <= step_in;
         ok_ff      <= ok_in;
         clamp_ff   <= clamp_in;
         end_new_ff <= end_new_in;
      end
      if (cmd.div_init) begin
         n_ff   <= n_in;
         num_ff <= n_in;
         rmd_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[31:0], trial_ge};
         rmd_ff <= trial_ge ? 26'(trial - {1'b0, step_ff}) : trial[25:0];
      end
      if (cmd.mul) begin
         hit_ff  <= (mstep < {1'b0, last_ff});
         mile_ff <= {10'b0, num_ff[16:0]} * {17'b0, interval_ff};
      end
      if (cmd.commit) begin
         acc_o_ff   <= acc_in;
         phase_o_ff <= phase_in;
         rem_o_ff   <= rem_o_in;
         fin_o_ff   <= fin_in;
         mile_o_ff  <= mile_in;
      end
   end

   assign rsp_accepted          = acc_o_ff;
   assign rsp_phase             = phase_o_ff;
   assign rsp_remaining_ms      = rem_o_ff;
   assign rsp_finished_now      = fin_o_ff;
   assign rsp_milestone_minutes = mile_o_ff;

endmodule

`default_nettype wire

// ===== rtl/countdown_with_reminders_top.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    mode, now_ms, duration_arg
// rsp       out        rsp_valid/rsp_ready    accepted, phase, remaining_ms,
//                                             finished_now, milestone_minutes
// csr       in         csr_wr_en              reminder_interval_min
//
// A poll that checks for a reminder milestone loads its result only after the
// 33-step serial divider has run; every other beat skips the divider.
// The next beat is accepted only once the result of the last one is loaded.
// Reset is synchronous and returns the timer to ready with the minimum duration.
// A stalled result holds in its register; the block waits before loading the next.

module countdown_with_reminders_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [47:0]        req_now_ms,
   input  logic signed [32:0] req_duration_arg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [1:0]         rsp_phase,
   output logic [31:0]        rsp_remaining_ms,
   output logic               rsp_finished_now,
   output logic [16:0]        rsp_milestone_minutes,
   input  logic               csr_wr_en,
   input  logic [9:0]         csr_wr_data
);
   import cwr_pkg::*;

   cmd_type    cmd;
   status_type status;

   cwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cwr_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_mode              (req_mode),
      .req_now_ms            (req_now_ms),
      .req_duration_arg      (req_duration_arg),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_accepted          (rsp_accepted),
      .rsp_phase             (rsp_phase),
      .rsp_remaining_ms      (rsp_remaining_ms),
      .rsp_finished_now      (rsp_finished_now),
      .rsp_milestone_minutes (rsp_milestone_minutes)
   );

endmodule

`default_nettype wire

// ===== rtl/cwr_checker.sv =====
`default_nettype none

module cwr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_accepted,
   input wire logic [1:0]  rsp_phase,
   input wire logic [31:0] rsp_remaining_ms,
   input wire logic        rsp_finished_now,
   input wire logic [16:0] rsp_milestone_minutes
);
   import cwr_pkg::*;

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_remaining_ms)
                                  && $stable(rsp_phase) && $stable(rsp_milestone_minutes))
      else $error("result beat changed while stalled");

   // The finish event leaves the timer finished with nothing remaining.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished_now |-> rsp_phase == PH_FINISHED
                                        && rsp_remaining_ms == '0 && rsp_accepted)
      else $error("finish event with inconsistent phase or time");

   // Milestones come only from accepted polls of a still running timer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_milestone_minutes != '0 |-> rsp_phase == PH_RUNNING
                                                   && !rsp_finished_now && rsp_accepted
                                                   && rsp_remaining_ms != '0)
      else $error("milestone outside a running poll");

   // A rejected command reports no event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_finished_now && rsp_milestone_minutes == '0)
      else $error("event reported on a rejected command");

endmodule

bind countdown_with_reminders_top cwr_checker u_cwr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_accepted          (rsp_accepted),
   .rsp_phase             (rsp_phase),
   .rsp_remaining_ms      (rsp_remaining_ms),
   .rsp_finished_now      (rsp_finished_now),
   .rsp_milestone_minutes (rsp_milestone_minutes)
);

`default_nettype wire

// ===== test/countdown_with_reminders_top_tb.sv =====
`timescale 1ns / 1ps

module countdown_with_reminders_top_tb;
   import cwr_pkg::*;

   localparam logic [2:0] MODE_UNDEF = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_SETTING = 100;
   localparam logic [47:0] T0 = 48'h7FFF_0000_0000;

   typedef struct packed {
      logic [2:0]         mode;
      logic [47:0]        now_ms;
      logic signed [32:0] arg;
   } timer_cmd_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  phase;
      logic [31:0] remaining_ms;
      logic        finished_now;
      logic [16:0] milestone_minutes;
   } timer_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_mode = '0;
   logic [47:0] req_now_ms = '0;
   logic signed [32:0] req_duration_arg = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_accepted;
   logic [1:0] rsp_phase;
   logic [31:0] rsp_remaining_ms;
   logic rsp_finished_now;
   logic [16:0] rsp_milestone_minutes;
   logic csr_wr_en = 1'b0;
   logic [9:0] csr_wr_data = '0;

   countdown_with_reminders_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_now_ms            (req_now_ms),
      .req_duration_arg      (req_duration_arg),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_phase             (rsp_phase),
      .rsp_remaining_ms      (rsp_remaining_ms),
      .rsp_finished_now      (rsp_finished_now),
      .rsp_milestone_minutes (rsp_milestone_minutes),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial forever #2 clock = ~clock;

   // Shadow copy of the timer state and its interval register.
   phase_type   shadow_phase;
   logic [31:0] shadow_duration;
   logic [31:0] shadow_held;
   logic [48:0] shadow_end;
   logic [31:0] shadow_last_seen;
   logic [9:0]  shadow_interval;

   timer_cmd_type    pending_cmds[$];
   timer_report_type expected_reports[$];

   int items_queued = 0;
   int items_accepted = 0;
   int phase_items = 0;
   int fail_count = 0;
   int reported = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   int gap_max = 0;
   int gap_left = 0;
   int burst_left = 1;
   logic [7:0] stall_mask = 8'hFF;
   logic [2:0] stall_phase = '0;
   logic [47:0] wall_ms;

   function automatic logic [31:0] shadow_remaining(logic [47:0] now);
      logic [63:0] gap;
      if (shadow_phase != PH_RUNNING) return shadow_held;
      if (64'(shadow_end) <= 64'(now)) return '0;
      gap = 64'(shadow_end) - 64'(now);
      return (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
   endfunction

   function automatic logic [31:0] clamp_ms(longint v);
      longint lo, hi;
      lo = MIN_DURATION_MS;
      hi = MAX_DURATION_MS;
      if (v < lo) return MIN_DURATION_MS;
      if (v > hi) return MAX_DURATION_MS;
      return 32'(v);
   endfunction

   // Edits are refused while the countdown is live and otherwise re-arm it.
   function automatic logic try_edit(longint v);
      if (shadow_phase == PH_RUNNING || shadow_phase == PH_PAUSED) return 1'b0;
      shadow_duration = clamp_ms(v);
      shadow_held = shadow_duration;
      shadow_phase = PH_READY;
      return 1'b1;
   endfunction

   task automatic apply_timer_command(input timer_cmd_type c, output timer_report_type r);
      logic [31:0] rem;
      logic [63:0] period_ms, prev, mult;
      longint arg_l, dur_l;
      r = '0;
      r.accepted = 1'b1;
      arg_l = $signed(c.arg);
      dur_l = shadow_duration;
      case (c.mode)
         MODE_POLL: begin
            if (shadow_phase == PH_RUNNING) begin
               rem = shadow_remaining(c.now_ms);
               if (rem == 0) begin
                  shadow_phase = PH_FINISHED;
                  shadow_held = '0;
                  shadow_last_seen = '0;
                  r.finished_now = 1'b1;
               end else if (shadow_interval != 0 && shadow_interval >= REMINDER_MIN &&
                            shadow_interval <= REMINDER_MAX) begin
                  period_ms = 64'(shadow_interval) * 64'(MS_PER_MIN);
                  prev = shadow_last_seen;
                  mult = (64'(rem) + period_ms - 1) / period_ms;
                  shadow_last_seen = rem;
                  if (mult >= 1 && mult * period_ms < prev) begin
                     mult = mult * shadow_interval;
                     r.milestone_minutes = (mult > 64'h1FFFF) ? 17'h1FFFF : mult[16:0];
                  end
               end
            end
         end
         MODE_START: begin
            if (shadow_phase == PH_RUNNING || shadow_phase == PH_PAUSED) begin
               r.accepted = 1'b0;
            end else begin
               shadow_end = 49'(64'(c.now_ms) + 64'(shadow_duration));
               shadow_held = shadow_duration;
               shadow_last_seen = shadow_duration;
               shadow_phase = PH_RUNNING;
            end
         end
         MODE_PAUSE: begin
            if (shadow_phase != PH_RUNNING) begin
               r.accepted = 1'b0;
            end else begin
               shadow_held = shadow_remaining(c.now_ms);
               shadow_phase = PH_PAUSED;
            end
         end
         MODE_RESUME: begin
            if (shadow_phase != PH_PAUSED) begin
               r.accepted = 1'b0;
            end else begin
               shadow_end = 49'(64'(c.now_ms) + 64'(shadow_held));
               shadow_phase = PH_RUNNING;
            end
         end
         MODE_RESET: begin
            shadow_phase = PH_READY;
            shadow_held = shadow_duration;
            shadow_end = '0;
            shadow_last_seen = '0;
         end
         MODE_SET: r.accepted = try_edit(arg_l);
         MODE_ADJUST: r.accepted = try_edit(dur_l + arg_l);
         default: r.accepted = 1'b0;
      endcase
      r.phase = shadow_phase;
      r.remaining_ms = shadow_remaining(c.now_ms);
   endtask

   function automatic logic signed [32:0] any_arg();
      return 33'({$urandom, $urandom});
   endfunction

   task automatic queue_cmd(input logic [2:0] mode, input logic [47:0] at_ms,
                            input logic signed [32:0] arg);
      timer_cmd_type c;
      c.mode = mode;
      c.now_ms = at_ms;
      c.arg = arg;
      pending_cmds.push_back(c);
      items_queued++;
      phase_items++;
   endtask

   task automatic queue_directed();
      queue_cmd(MODE_POLL, T0, 33'sd0);
      queue_cmd(MODE_PAUSE, T0, 33'sd0);
      queue_cmd(MODE_RESUME, T0, 33'sd0);
      queue_cmd(MODE_UNDEF, 48'hFFFF_FFFF_FFFF, 33'h1_FFFF_FFFF);
      queue_cmd(MODE_SET, T0, 33'h1_0000_0000);
      queue_cmd(MODE_SET, T0, 33'h0_FFFF_FFFF);
      queue_cmd(MODE_ADJUST, T0, 33'h1_FFFF_FFFF);
      queue_cmd(MODE_SET, T0, 33'sd180000);
      queue_cmd(MODE_START, T0, 33'sd0);
      queue_cmd(MODE_START, T0 + 48'd1000, 33'sd0);
      queue_cmd(MODE_POLL, T0 + 48'd61000, 33'sd0);
      queue_cmd(MODE_SET, T0 + 48'd61000, 33'sd5000);
      queue_cmd(MODE_PAUSE, T0 + 48'd70000, 33'sd0);
      queue_cmd(MODE_POLL, T0 + 48'd500000, 33'sd0);
      queue_cmd(MODE_ADJUST, T0 + 48'd500000, 33'sd5);
      queue_cmd(MODE_RESUME, T0 + 48'd600000, 33'sd0);
      // A timestamp far behind the end time saturates the remaining time.
      queue_cmd(MODE_POLL, 48'd0, 33'sd0);
      queue_cmd(MODE_POLL, T0 + 48'd650000, 33'sd0);
      queue_cmd(MODE_POLL, T0 + 48'd710000, 33'sd0);
      queue_cmd(MODE_POLL, T0 + 48'd720000, 33'sd0);
      queue_cmd(MODE_ADJUST, T0 + 48'd720000, 33'sd0);
      queue_cmd(MODE_START, T0 + 48'd730000, 33'sd0);
      queue_cmd(MODE_RESET, T0 + 48'd740000, 33'sd0);
      queue_cmd(MODE_POLL, 48'd0, 33'sd0);
   endtask

   // One countdown from arming, most often run on to its finish, with random timing and detours.
   task automatic queue_countdown_run();
      int unsigned span, reach, polls, i;
      int delta;
      queue_cmd(MODE_RESET, wall_ms, any_arg());
      span = $urandom_range(1000, 600000);
      reach = span;
      case ($urandom_range(0, 9))
         0: begin
            queue_cmd(MODE_SET, wall_ms, any_arg());
            span = 60000;
            reach = MAX_DURATION_MS;
         end
         1: begin
            span = 1000;
            reach = 1000;
            queue_cmd(MODE_SET, wall_ms, 33'($urandom_range(0, 999)));
         end
         2: begin
            span = $urandom_range(600001, MAX_DURATION_MS);
            reach = span;
            queue_cmd(MODE_SET, wall_ms, 33'(span));
         end
         3: begin
            span = MAX_DURATION_MS;
            reach = span;
            queue_cmd(MODE_SET, wall_ms, 33'($urandom_range(MAX_DURATION_MS + 1, 32'hFFFF_FFFF)));
         end
         4, 5: begin
            queue_cmd(MODE_SET, wall_ms, 33'(span));
            delta = $urandom_range(0, 2 * span) - span;
            reach = 2 * span;
            queue_cmd(MODE_ADJUST, wall_ms, 33'(delta));
         end
         6: reach = MAX_DURATION_MS;
         default: queue_cmd(MODE_SET, wall_ms, 33'(span));
      endcase
      queue_cmd(MODE_START, wall_ms, any_arg());
      polls = $urandom_range(2, 10);
      for (i = 0; i < polls; i++) begin
         case ($urandom_range(0, 15))
            0: begin
               wall_ms += $urandom_range(0, span / 4);
               queue_cmd(MODE_PAUSE, wall_ms, any_arg());
               wall_ms += $urandom_range(0, 4 * span);
               queue_cmd(3'($urandom_range(0, 6)), wall_ms, any_arg());
               queue_cmd(MODE_RESUME, wall_ms, any_arg());
            end
            1: queue_cmd(MODE_POLL, wall_ms - 48'($urandom_range(0, span)), any_arg());
            2: queue_cmd(3'($urandom_range(1, 7)), wall_ms, any_arg());
            default: begin
               wall_ms += $urandom_range(0, span / 3);
               queue_cmd(MODE_POLL, wall_ms, any_arg());
            end
         endcase
      end
      if ($urandom_range(0, 3) != 0) begin
         wall_ms += reach;
         queue_cmd(MODE_POLL, wall_ms, any_arg());
         queue_cmd(MODE_POLL, wall_ms, any_arg());
         if ($urandom_range(0, 1) == 1) begin
            queue_cmd($urandom_range(0, 1) ? MODE_SET : MODE_ADJUST, wall_ms, any_arg());
            queue_cmd(MODE_START, wall_ms, any_arg());
            wall_ms += $urandom_range(0, 600000);
            queue_cmd(MODE_POLL, wall_ms, any_arg());
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (items_accepted != items_queued || expected_reports.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Sender: bursts of beats separated by random gaps.
   always @(negedge clock) begin : drive
      timer_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0 || pending_cmds.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            c = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_mode <= c.mode;
            req_now_ms <= c.now_ms;
            req_duration_arg <= c.arg;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end
      end
      stall_phase <= stall_phase + 3'd1;
      rsp_ready <= stall_mask[stall_phase];
   end

   always @(posedge clock) begin : check
      timer_cmd_type c;
      timer_report_type want, got;
      if (reset) begin
         shadow_phase = PH_READY;
         shadow_duration = MIN_DURATION_MS;
         shadow_held = MIN_DURATION_MS;
         shadow_end = '0;
         shadow_last_seen = '0;
         shadow_interval = '0;
         req_taken <= 1'b0;
      end else begin
         if (csr_wr_en) shadow_interval = csr_wr_data;
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            c.mode = req_mode;
            c.now_ms = req_now_ms;
            c.arg = req_duration_arg;
            apply_timer_command(c, want);
            expected_reports.push_back(want);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            got.accepted = rsp_accepted;
            got.phase = rsp_phase;
            got.remaining_ms = rsp_remaining_ms;
            got.finished_now = rsp_finished_now;
            got.milestone_minutes = rsp_milestone_minutes;
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected result beat: acc=%0d phase=%0d rem=%0d fin=%0d mile=%0d",
                           got.accepted, got.phase, got.remaining_ms, got.finished_now,
                           got.milestone_minutes);
               end
            end else begin
               want = expected_reports.pop_front();
               if (got.accepted !== want.accepted || got.phase !== want.phase ||
                   got.remaining_ms !== want.remaining_ms ||
                   got.finished_now !== want.finished_now ||
                   got.milestone_minutes !== want.milestone_minutes) begin
                  fail_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("mismatch: expected acc=%0d phase=%0d rem=%0d fin=%0d mile=%0d",
                              want.accepted, want.phase, want.remaining_ms,
                              want.finished_now, want.milestone_minutes);
                     $display("          actual   acc=%0d phase=%0d rem=%0d fin=%0d mile=%0d",
                              got.accepted, got.phase, got.remaining_ms, got.finished_now,
                              got.milestone_minutes);
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : main
      logic [9:0] intervals[6];
      int p;
      intervals = '{10'd1, 10'd720, 10'd7, 10'd0, 10'd1023, 10'd721};
      intervals[2] = $urandom_range(2, 60);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (p = 0; p < 6; p++) begin
         wait_idle();
         csr_wr_en <= 1'b1;
         csr_wr_data <= intervals[p];
         @(negedge clock);
         csr_wr_en <= 1'b0;
         @(posedge clock);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         wall_ms = {1'b0, 47'({$urandom, $urandom})};
         phase_items = 0;
         if (p == 0) queue_directed();
         while (phase_items < ITEMS_PER_SETTING) begin
            if ($urandom_range(0, 6) == 0) begin
               queue_cmd(3'($urandom_range(0, 7)), 48'({$urandom, $urandom}), any_arg());
            end else begin
               queue_countdown_run();
            end
         end
      end
      wait_idle();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
